/* sv/serial_frame_receiver_dp_parser_macros.svh */
// Assertion macros for the serial frame receiver with data-point parser.
// Included by the modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef SERIAL_FRAME_RECEIVER_DP_PARSER_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_DP_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define SFRDP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfrdp assertion failed");
// Next-cycle implication, checked out of reset.
`define SFRDP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfrdp assertion failed");
`else
`define SFRDP_ASSERT_IMPL(lbl, ante, cons)
`define SFRDP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/sfrdp_pkg.sv */
// Shared types and constants of the serial frame receiver with data-point parser.
// No dependencies; imported by the controller, the datapath and the top level.
package sfrdp_pkg;

	localparam int DefMaxPayload = 128;
	localparam int MaxRecords = 32;
	localparam int RecHdrLen = 4;
	localparam int RecBufLen = 8;

	localparam logic [7:0] SYNC_FIRST = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [7:0] CMD_DATAPOINT = 8'h07;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_BAD_SUM = 2'd1,
		STAT_TOO_LONG = 2'd2
	} frame_status_t;

	typedef enum logic {
		KIND_SUMMARY = 1'b0,
		KIND_RECORD = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic skip1;
		logic skip2;
		logic clr_skip;
		logic sum_init;
		logic sum_add;
		logic ld_ver;
		logic ld_cmd;
		logic ld_lenh;
		logic ld_lenl;
		logic pay_wr;
		logic ld_status;
		logic out_summ;
		logic out_rec;
		logic walk_start;
		logic fetch_clr;
		logic fetch_step;
	} sfrdp_cmd_t;

	typedef struct packed {
		logic is_sync_first;
		logic is_sync_second;
		logic len_zero;
		logic pay_last;
		logic out_free;
		logic walk_first;
		logic walk_more;
		logic fetch_done;
	} sfrdp_sts_t;

endpackage

/* sv/sfrdp_ctrl.sv */
// Controller of the frame receiver: frame phase and record-walk sequencing.
// Depends on sfrdp_pkg; drives commands to sfrdp_dpath and reads its status.
module sfrdp_ctrl import sfrdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  sfrdp_sts_t sts,
	output sfrdp_cmd_t cmd
);

	typedef enum logic [10:0] {
		S_HUNT  = 11'b000_0000_0001,
		S_HDR2  = 11'b000_0000_0010,
		S_VER   = 11'b000_0000_0100,
		S_CMD   = 11'b000_0000_1000,
		S_LENH  = 11'b000_0001_0000,
		S_LENL  = 11'b000_0010_0000,
		S_PAY   = 11'b000_0100_0000,
		S_CSUM  = 11'b000_1000_0000,
		S_SUMM  = 11'b001_0000_0000,
		S_FETCH = 11'b010_0000_0000,
		S_REC   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign take = byte_valid && byte_ready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		byte_ready = 1'b0;
		unique case (state_q)
			S_HUNT: begin
				byte_ready = 1'b1;
				if (take) begin
					if (sts.is_sync_first) state_d = S_HDR2;
					else cmd.skip1 = 1'b1;
				end
			end
			S_HDR2: begin
				byte_ready = 1'b1;
				if (take) begin
					if (sts.is_sync_second) begin
						cmd.sum_init = 1'b1;
						state_d = S_VER;
					end else if (sts.is_sync_first) begin
						cmd.skip1 = 1'b1;
					end else begin
						cmd.skip2 = 1'b1;
						state_d = S_HUNT;
					end
				end
			end
			S_VER: begin
				byte_ready = 1'b1;
				if (take) begin
					cmd.ld_ver = 1'b1;
					cmd.sum_add = 1'b1;
					state_d = S_CMD;
				end
			end
			S_CMD: begin
				byte_ready = 1'b1;
				if (take) begin
					cmd.ld_cmd = 1'b1;
					cmd.sum_add = 1'b1;
					state_d = S_LENH;
				end
			end
			S_LENH: begin
				byte_ready = 1'b1;
				if (take) begin
					cmd.ld_lenh = 1'b1;
					cmd.sum_add = 1'b1;
					state_d = S_LENL;
				end
			end
			S_LENL: begin
				byte_ready = 1'b1;
				if (take) begin
					cmd.ld_lenl = 1'b1;
					cmd.sum_add = 1'b1;
					state_d = sts.len_zero ? S_CSUM : S_PAY;
				end
			end
			S_PAY: begin
				byte_ready = 1'b1;
				if (take) begin
					cmd.pay_wr = 1'b1;
					cmd.sum_add = 1'b1;
					if (sts.pay_last) state_d = S_CSUM;
				end
			end
			S_CSUM: begin
				byte_ready = 1'b1;
				if (take) begin
					cmd.ld_status = 1'b1;
					state_d = S_SUMM;
				end
			end
			S_SUMM: begin
				if (sts.out_free) begin
					cmd.out_summ = 1'b1;
					if (sts.walk_first) begin
						cmd.walk_start = 1'b1;
						state_d = S_FETCH;
					end else begin
						cmd.clr_skip = 1'b1;
						state_d = S_HUNT;
					end
				end
			end
			S_FETCH: begin
				cmd.fetch_step = 1'b1;
				if (sts.fetch_done) state_d = S_REC;
			end
			S_REC: begin
				if (sts.out_free) begin
					cmd.out_rec = 1'b1;
					if (sts.walk_more) begin
						cmd.fetch_clr = 1'b1;
						state_d = S_FETCH;
					end else begin
						cmd.clr_skip = 1'b1;
						state_d = S_HUNT;
					end
				end
			end
			default: begin
				state_d = S_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_HUNT;
		else state_q <= state_d;
	end

endmodule

/* sv/sfrdp_dpath.sv */
// Datapath of the frame receiver: frame registers, payload store, record fetch
// and the result register. Depends on sfrdp_pkg and the assertion macro header.
`include "serial_frame_receiver_dp_parser_macros.svh"
module sfrdp_dpath import sfrdp_pkg::*; #(
	parameter int MAX_PAYLOAD = DefMaxPayload
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  sfrdp_cmd_t         cmd,
	output sfrdp_sts_t         sts,
	output logic               res_valid,
	input  logic               res_ready,
	output logic               kind,
	output logic [1:0]         status,
	output logic [7:0]         version,
	output logic [7:0]         command,
	output logic [15:0]        frame_length,
	output logic [15:0]        skipped_bytes,
	output logic [7:0]         dp_id,
	output logic [7:0]         dp_type,
	output logic [15:0]        dp_length,
	output logic signed [31:0] dp_value,
	output logic               last
);

	localparam int AW = $clog2(MAX_PAYLOAD);
	localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);
	localparam int FetchDone = RecBufLen + 1;
	localparam int FW = $clog2(FetchDone + 1);
	localparam int IW = $clog2(RecBufLen);
	localparam int RW = $clog2(MaxRecords + 1);

	logic [7:0]    mem [MAX_PAYLOAD];

	logic [7:0]    version_q, command_q, sum_q;
	logic [15:0]   len_q, cnt_q, skip_q;
	frame_status_t status_q;

	logic [16:0]   ofs_q;
	logic [RW-1:0] rec_cnt_q;
	logic [FW-1:0] fetch_q;
	logic [7:0]    rec_q [RecBufLen];

	logic [7:0]    rd_s1;
	logic          zero_s1, cap_v_s1;
	logic [IW-1:0] cap_idx_s1;

	logic          mem_we, issue, fetch_done;
	logic [16:0]   pos, ofs_nxt, skip_sum;
	logic [15:0]   dl;
	logic [31:0]   value;
	logic          walk_first, walk_more;

	assign mem_we = cmd.pay_wr && (len_q <= MaxLen) && (cnt_q < MaxLen);
	assign issue = cmd.fetch_step && (fetch_q < FW'(RecBufLen));
	assign fetch_done = (fetch_q == FW'(FetchDone));
	assign pos = ofs_q + 17'(fetch_q[IW-1:0]);

	assign dl = {rec_q[2], rec_q[3]};
	assign ofs_nxt = ofs_q + 17'(RecHdrLen) + 17'(dl);

	always_comb begin
		if (dl == 16'd1) value = {24'd0, rec_q[4]};
		else if (dl == 16'd4) value = {rec_q[4], rec_q[5], rec_q[6], rec_q[7]};
		else value = '0;
	end

	assign walk_first = (status_q == STAT_OK) && (command_q == CMD_DATAPOINT) &&
		(len_q >= 16'(RecHdrLen));
	// Another record follows only if its header fits and the per-frame limit allows it.
	assign walk_more = ((ofs_nxt + 17'(RecHdrLen)) <= {1'b0, len_q}) &&
		((rec_cnt_q + RW'(1)) < RW'(MaxRecords));

	assign skip_sum = {1'b0, skip_q} + (cmd.skip2 ? 17'd2 : 17'd1);

	assign sts.is_sync_first = (rx_byte == SYNC_FIRST);
	assign sts.is_sync_second = (rx_byte == SYNC_SECOND);
	assign sts.len_zero = ({len_q[15:8], rx_byte} == 16'd0);
	assign sts.pay_last = ((17'(cnt_q) + 17'd1) >= {1'b0, len_q});
	assign sts.out_free = !res_valid || res_ready;
	assign sts.walk_first = walk_first;
	assign sts.walk_more = walk_more;
	assign sts.fetch_done = fetch_done;

	// Payload store and its registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) mem[cnt_q[AW-1:0]] <= rx_byte;
		if (issue) rd_s1 <= mem[pos[AW-1:0]];
	end

	// Frame registers.
	always_ff @(posedge clk) begin
		if (cmd.ld_ver) version_q <= rx_byte;
		if (cmd.ld_cmd) command_q <= rx_byte;
		if (cmd.ld_lenh) len_q <= {rx_byte, 8'h00};
		if (cmd.ld_lenl) len_q[7:0] <= rx_byte;
		if (cmd.ld_lenl) cnt_q <= '0;
		else if (cmd.pay_wr) cnt_q <= cnt_q + 16'd1;
		if (cmd.sum_init) sum_q <= SYNC_FIRST + SYNC_SECOND;
		else if (cmd.sum_add) sum_q <= sum_q + rx_byte;
		if (cmd.ld_status) begin
			if (len_q > MaxLen) status_q <= STAT_TOO_LONG;
			else if (sum_q != rx_byte) status_q <= STAT_BAD_SUM;
			else status_q <= STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
		end else if (cmd.clr_skip) begin
			skip_q <= '0;
		end else if (cmd.skip1 || cmd.skip2) begin
			skip_q <= skip_sum[16] ? 16'hFFFF : skip_sum[15:0];
		end
	end

	// Record walk: offset, record count and the eight-byte fetch window.
	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			ofs_q <= '0;
			rec_cnt_q <= '0;
		end else if (cmd.out_rec) begin
			ofs_q <= ofs_nxt;
			rec_cnt_q <= rec_cnt_q + RW'(1);
		end
		zero_s1 <= (pos >= {1'b0, len_q});
		cap_idx_s1 <= fetch_q[IW-1:0];
		if (cap_v_s1) rec_q[cap_idx_s1] <= zero_s1 ? 8'd0 : rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_q <= '0;
			cap_v_s1 <= 1'b0;
		end else begin
			cap_v_s1 <= issue;
			if (cmd.walk_start || cmd.fetch_clr) fetch_q <= '0;
			else if (cmd.fetch_step && !fetch_done) fetch_q <= fetch_q + FW'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else if (cmd.out_summ || cmd.out_rec) res_valid <= 1'b1;
		else if (res_ready) res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_summ || cmd.out_rec) begin
			version <= version_q;
			command <= command_q;
			frame_length <= len_q;
			skipped_bytes <= skip_q;
		end
		if (cmd.out_summ) begin
			kind <= KIND_SUMMARY;
			status <= status_q;
			dp_id <= '0;
			dp_type <= '0;
			dp_length <= '0;
			dp_value <= '0;
			last <= !walk_first;
		end else if (cmd.out_rec) begin
			kind <= KIND_RECORD;
			status <= STAT_OK;
			dp_id <= rec_q[0];
			dp_type <= rec_q[1];
			dp_length <= dl;
			dp_value <= signed'(value);
			last <= !walk_more;
		end
	end

	`SFRDP_ASSERT_IMPL(a_rec_after_fetch, cmd.out_rec, fetch_done)
	`SFRDP_ASSERT_IMPL(a_store_only_fits, mem_we, len_q <= MaxLen)
	`SFRDP_ASSERT_NEXT(a_walk_from_zero, cmd.walk_start, ofs_q == '0 && rec_cnt_q == '0)
	`SFRDP_ASSERT_IMPL(a_walk_ok, cmd.walk_start, status_q == STAT_OK)
	`SFRDP_ASSERT_IMPL(a_rec_limit, cmd.out_rec, rec_cnt_q < RW'(MaxRecords))

endmodule

/* sv/serial_frame_receiver_dp_parser.sv */
// Channel   Handshake                Words
// byte      byte_valid / byte_ready  rx_byte
// result    res_valid / res_ready    kind status version command frame_length
//                                    skipped_bytes dp_id dp_type dp_length dp_value last
// The checksum byte is followed by loading the frame summary, then for each record
// by reading eight store bytes through the registered read port of the payload store
// and loading the record.
// Bytes are refused after the checksum byte until the last word of the frame is loaded.
// A stalled result holds the walk; reset clears the controller and returns to header hunting.
// Top level of the serial frame receiver; depends on sfrdp_pkg, sfrdp_ctrl and sfrdp_dpath.
module serial_frame_receiver_dp_parser import sfrdp_pkg::*; #(
	parameter int MAX_PAYLOAD = DefMaxPayload
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	input  logic               res_ready,
	output logic               kind,
	output logic [1:0]         status,
	output logic [7:0]         version,
	output logic [7:0]         command,
	output logic [15:0]        frame_length,
	output logic [15:0]        skipped_bytes,
	output logic [7:0]         dp_id,
	output logic [7:0]         dp_type,
	output logic [15:0]        dp_length,
	output logic signed [31:0] dp_value,
	output logic               last
);

	sfrdp_cmd_t cmd;
	sfrdp_sts_t sts;

	sfrdp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	sfrdp_dpath #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.sts           (sts),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.kind          (kind),
		.status        (status),
		.version       (version),
		.command       (command),
		.frame_length  (frame_length),
		.skipped_bytes (skipped_bytes),
		.dp_id         (dp_id),
		.dp_type       (dp_type),
		.dp_length     (dp_length),
		.dp_value      (dp_value),
		.last          (last)
	);

endmodule
